/* src/crcfc_pkg.sv */
// ============================================================================
// crcfc_pkg
// Shared types, constants and the byte-wide CRC-16 update for the frame
// checker.
// ============================================================================
`default_nettype none

package crcfc_pkg;

    localparam logic [7:0]  START_MARKER_RST = 8'h9B;
    localparam logic [7:0]  END_MARKER_RST   = 8'h9D;
    localparam logic [7:0]  HEIGHT_TYPE_RST  = 8'h12;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [7:0]  COUNT_MAX        = 8'hFF;
    localparam int          MIN_LEN          = 4;

    typedef enum logic [1:0] {
        REG_START_MARKER = 2'd0,
        REG_END_MARKER   = 2'd1,
        REG_HEIGHT_TYPE  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_START = 3'd2,
        ST_BAD_END   = 3'd3,
        ST_CRC_ERR   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] height_type;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  frame_length;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
        logic        is_height;
        logic [7:0]  message_type;
        status_t     status;
    } verdict_t;

    // reflected CRC-16, one byte, unrolled over its eight bits
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/crc16_frame_checker_top.sv */
// ============================================================================
// crc16_frame_checker_top
// Byte-stream frame checker: CRC-16 (Modbus) over the body, marker checks,
// one verdict word per frame.
//
//   channel | dir | ports                          | content
//   s_      | in  | s_tvalid s_tready s_tdata s_tlast | frame byte, last-byte flag
//   m_      | out | m_tvalid m_tready m_tdata       | verdict, one per frame
//   cfg_    | in  | cfg_we cfg_addr cfg_wdata      | marker and type registers
//
// One byte per cycle sustained: input register, then one unrolled 8-bit CRC
// update and compare, then the verdict register.
// aresetn (synchronous) clears frame state and restores register defaults.
// A stalled verdict only holds back a following last byte; body bytes flow.
// ============================================================================
`default_nettype none

module crc16_frame_checker_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [55:0] m_tdata,   // status, message_type, is_height,
                                        // computed_crc, received_crc,
                                        // frame_length, zero pad
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);

    crcfc_pkg::cfg_t     cfg;
    crcfc_pkg::verdict_t verdict;

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                out_valid_reg, out_valid_next;
    crcfc_pkg::verdict_t out_reg;
    logic                advance;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = (advance && in_last_reg) || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_reg <= verdict;
        end
    end

    crcfc_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    crcfc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .verdict   (verdict)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_reg.frame_length, out_reg.received_crc,
                       out_reg.computed_crc, out_reg.is_height,
                       out_reg.message_type, out_reg.status};

    a_verdict_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("verdict appeared without a last byte");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !(advance && in_last_reg))
        else $error("pending verdict overwritten");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input byte lost");

endmodule

`default_nettype wire

/* src/crcfc_regs.sv */
// ============================================================================
// crcfc_regs
// Configuration registers: start marker, end marker, height type.
// ============================================================================
`default_nettype none

module crcfc_regs (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_addr,
    input  wire logic [7:0]       cfg_wdata,
    output crcfc_pkg::cfg_t       cfg
);

    crcfc_pkg::cfg_t cfg_reg;
    crcfc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                crcfc_pkg::REG_START_MARKER: cfg_next.start_marker = cfg_wdata;
                crcfc_pkg::REG_END_MARKER:   cfg_next.end_marker   = cfg_wdata;
                crcfc_pkg::REG_HEIGHT_TYPE:  cfg_next.height_type  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker <= crcfc_pkg::START_MARKER_RST;
            cfg_reg.end_marker   <= crcfc_pkg::END_MARKER_RST;
            cfg_reg.height_type  <= crcfc_pkg::HEIGHT_TYPE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/crcfc_core.sv */
// ============================================================================
// crcfc_core
// Per-frame state (running CRC, three-byte delay line, byte count, start and
// type captures) and the end-of-frame verdict.
// ============================================================================
`default_nettype none

module crcfc_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire crcfc_pkg::cfg_t cfg,
    input  wire logic            step,
    input  wire logic [7:0]      data_byte,
    input  wire logic            last,
    output crcfc_pkg::verdict_t  verdict
);

    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  dly0_reg,     dly0_next;
    logic [7:0]  dly1_reg,     dly1_next;
    logic [7:0]  dly2_reg,     dly2_next;
    logic [7:0]  count_reg,    count_next;
    logic        start_ok_reg, start_ok_next;
    logic [7:0]  type_reg,     type_next;

    logic [15:0] crc_upd;
    logic        start_ok_upd;
    logic [7:0]  type_upd;
    logic [7:0]  len;
    logic [15:0] rx;
    logic        short_frame;

    assign start_ok_upd = (count_reg == 8'd0) ? (data_byte == cfg.start_marker) : start_ok_reg;
    assign type_upd     = (count_reg == 8'd2) ? data_byte : type_reg;
    assign crc_upd      = (count_reg >= 8'(crcfc_pkg::MIN_LEN))
                        ? crcfc_pkg::crc_feed(crc_reg, dly2_reg) : crc_reg;
    assign len          = (count_reg != crcfc_pkg::COUNT_MAX) ? count_reg + 8'd1
                                                              : crcfc_pkg::COUNT_MAX;
    assign rx           = {dly1_reg, dly0_reg};
    assign short_frame  = (len < 8'(crcfc_pkg::MIN_LEN));

    always_comb begin
        verdict.message_type = type_upd;
        verdict.frame_length = len;
        verdict.computed_crc = short_frame ? crcfc_pkg::CRC_INIT : crc_upd;
        verdict.received_crc = short_frame ? 16'h0000 : rx;
        if (short_frame) begin
            verdict.status = crcfc_pkg::ST_SHORT;
        end else if (!start_ok_upd) begin
            verdict.status = crcfc_pkg::ST_BAD_START;
        end else if (data_byte != cfg.end_marker) begin
            verdict.status = crcfc_pkg::ST_BAD_END;
        end else if (rx != crc_upd) begin
            verdict.status = crcfc_pkg::ST_CRC_ERR;
        end else begin
            verdict.status = crcfc_pkg::ST_OK;
        end
        verdict.is_height = (verdict.status == crcfc_pkg::ST_OK)
                         && (type_upd == cfg.height_type);
    end

    always_comb begin
        crc_next      = crc_reg;
        dly0_next     = dly0_reg;
        dly1_next     = dly1_reg;
        dly2_next     = dly2_reg;
        count_next    = count_reg;
        start_ok_next = start_ok_reg;
        type_next     = type_reg;
        if (step) begin
            if (last) begin
                crc_next      = crcfc_pkg::CRC_INIT;
                dly0_next     = 8'd0;
                dly1_next     = 8'd0;
                dly2_next     = 8'd0;
                count_next    = 8'd0;
                start_ok_next = 1'b0;
                type_next     = 8'd0;
            end else begin
                crc_next      = crc_upd;
                dly2_next     = dly1_reg;
                dly1_next     = dly0_reg;
                dly0_next     = data_byte;
                count_next    = len;
                start_ok_next = start_ok_upd;
                type_next     = type_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= crcfc_pkg::CRC_INIT;
            dly0_reg     <= 8'd0;
            dly1_reg     <= 8'd0;
            dly2_reg     <= 8'd0;
            count_reg    <= 8'd0;
            start_ok_reg <= 1'b0;
            type_reg     <= 8'd0;
        end else begin
            crc_reg      <= crc_next;
            dly0_reg     <= dly0_next;
            dly1_reg     <= dly1_next;
            dly2_reg     <= dly2_next;
            count_reg    <= count_next;
            start_ok_reg <= start_ok_next;
            type_reg     <= type_next;
        end
    end

    a_idle_state_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 8'd0 |-> (crc_reg == crcfc_pkg::CRC_INIT) && !start_ok_reg)
        else $error("frame state not clean at byte zero");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && last |=> count_reg == 8'd0 && type_reg == 8'd0)
        else $error("frame state not cleared after last byte");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !last && count_reg == crcfc_pkg::COUNT_MAX |=> count_reg == crcfc_pkg::COUNT_MAX)
        else $error("byte count wrapped");

    a_crc_frozen_early: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !last && count_reg < 8'(crcfc_pkg::MIN_LEN) |=> $stable(crc_reg))
        else $error("crc changed before delay line filled");

endmodule

`default_nettype wire

/* sim/crc16_frame_checker_top_tb.sv */
// ============================================================================
// crc16_frame_checker_top_tb
// Self-checking bench for the CRC-16 frame checker. Frames are streamed in
// byte by byte and each byte updates a local predictor of the checker. Every
// verdict word is compared field by field against the oldest predicted
// verdict. Covered: short frames, bad markers, CRC errors, length
// saturation, full rate, output backpressure and several register settings.
// ============================================================================
`default_nettype none

module crc16_frame_checker_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        FR_GOOD,
        FR_BAD_START,
        FR_BAD_END,
        FR_BAD_CRC,
        FR_NOISE
    } frame_kind_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] data_byte
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;           // [2:0] status, [10:3] message_type,
                                    // [11] is_height, [27:12] computed_crc,
                                    // [43:28] received_crc, [51:44] frame_length
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [7:0]  cfg_wdata = '0;

    // register shadow
    logic [7:0]  cfg_start  = crcfc_pkg::START_MARKER_RST;
    logic [7:0]  cfg_end    = crcfc_pkg::END_MARKER_RST;
    logic [7:0]  cfg_height = crcfc_pkg::HEIGHT_TYPE_RST;

    // frame tracker state
    logic [15:0] tr_crc;
    logic [7:0]  tr_dly [3];
    logic [7:0]  tr_count;
    logic        tr_start_ok;
    logic [7:0]  tr_type;

    crcfc_pkg::verdict_t verdict_q [$];
    logic [7:0]  frame_buf [$];
    int          err_count  = 0;
    int          bytes_sent = 0;
    bit          src_idle   = 1'b1;
    bit          sink_idle  = 1'b1;
    int          hold_req   = 0;
    int          hold_left  = 0;

    crc16_frame_checker_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("crc16_frame_checker_top: mismatch");
        $finish;
    end

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_err($sformatf("%s: got %h, want %h", name, got, want));
        end
    endtask

    function automatic logic [15:0] crc16_step(input logic [15:0] c,
                                               input logic [7:0]  d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        repeat (8) begin
            r = r[0] ? ((r >> 1) ^ crcfc_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic clear_track();
        tr_crc      = crcfc_pkg::CRC_INIT;
        tr_dly      = '{default: 8'h00};
        tr_count    = '0;
        tr_start_ok = 1'b0;
        tr_type     = '0;
    endtask

    // advance the tracker by one accepted byte; a last byte yields a verdict
    task automatic track_byte(input logic [7:0] b, input logic l);
        crcfc_pkg::verdict_t v;
        logic [7:0] idx;
        int         len;
        idx = tr_count;
        if (idx == 0) tr_start_ok = (b == cfg_start);
        if (idx == 2) tr_type = b;
        if (idx >= 4) tr_crc = crc16_step(tr_crc, tr_dly[2]);
        if (!l) begin
            tr_dly[2] = tr_dly[1];
            tr_dly[1] = tr_dly[0];
            tr_dly[0] = b;
            if (tr_count != crcfc_pkg::COUNT_MAX) tr_count++;
        end else begin
            len = (idx == crcfc_pkg::COUNT_MAX) ? int'(crcfc_pkg::COUNT_MAX)
                                                : int'(idx) + 1;
            v.computed_crc = tr_crc;
            v.received_crc = {tr_dly[1], tr_dly[0]};
            if (len < crcfc_pkg::MIN_LEN) begin
                v.status       = crcfc_pkg::ST_SHORT;
                v.computed_crc = crcfc_pkg::CRC_INIT;
                v.received_crc = '0;
            end else if (!tr_start_ok) begin
                v.status = crcfc_pkg::ST_BAD_START;
            end else if (b != cfg_end) begin
                v.status = crcfc_pkg::ST_BAD_END;
            end else if (v.received_crc != v.computed_crc) begin
                v.status = crcfc_pkg::ST_CRC_ERR;
            end else begin
                v.status = crcfc_pkg::ST_OK;
            end
            v.message_type = tr_type;
            v.is_height    = (v.status == crcfc_pkg::ST_OK) && (tr_type == cfg_height);
            v.frame_length = len[7:0];
            verdict_q.push_back(v);
            clear_track();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        while (src_idle && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // fill frame_buf with random bytes; unless noise, set markers, type and CRC per current registers, then corrupt
    task automatic build_frame(input int len, input frame_kind_t kind, input bit height);
        logic [15:0] c;
        int          pos;
        frame_buf.delete();
        for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
        if (kind == FR_NOISE) return;
        frame_buf[0] = cfg_start;
        if (len >= 3 && height) frame_buf[2] = cfg_height;
        if (len >= 4) begin
            c = crcfc_pkg::CRC_INIT;
            for (int i = 1; i <= len - 4; i++) c = crc16_step(c, frame_buf[i]);
            frame_buf[len-3] = c[15:8];
            frame_buf[len-2] = c[7:0];
        end
        frame_buf[len-1] = cfg_end;
        case (kind)
            FR_BAD_START: frame_buf[0] ^= 8'(1 << $urandom_range(7));
            FR_BAD_END:   frame_buf[len-1] ^= 8'(1 << $urandom_range(7));
            FR_BAD_CRC: begin
                if (len >= 3) begin
                    pos = $urandom_range(len - 2, 1);
                    frame_buf[pos] ^= 8'(1 << $urandom_range(7));
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_random_frame();
        int          len;
        int          r;
        frame_kind_t kind;
        if ($urandom_range(9) == 0) len = $urandom_range(3, 1);
        else if ($urandom_range(39) == 0) len = $urandom_range(80, 40);
        else len = $urandom_range(24, 4);
        r = $urandom_range(99);
        if (r < 64) kind = FR_GOOD;
        else if (r < 73) kind = FR_BAD_START;
        else if (r < 82) kind = FR_BAD_END;
        else if (r < 93) kind = FR_BAD_CRC;
        else kind = FR_NOISE;
        build_frame(len, kind, $urandom_range(2) == 0);
        send_frame();
    endtask

    task automatic wait_idle();
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (verdict_q.size() != 0 && n < 5000) begin
            @(posedge aclk);
            n++;
        end
        repeat (4) @(posedge aclk);
        while (verdict_q.size() != 0) begin
            report_err("verdict never arrived");
            void'(verdict_q.pop_front());
        end
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        case (addr)
            crcfc_pkg::REG_START_MARKER: cfg_start  = val;
            crcfc_pkg::REG_END_MARKER:   cfg_end    = val;
            crcfc_pkg::REG_HEIGHT_TYPE:  cfg_height = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] st, input logic [7:0] en,
                            input logic [7:0] ht);
        write_reg(crcfc_pkg::REG_START_MARKER, st);
        write_reg(crcfc_pkg::REG_END_MARKER, en);
        write_reg(crcfc_pkg::REG_HEIGHT_TYPE, ht);
        write_reg(REG_UNUSED, 8'($urandom));
    endtask

    // receiver: random stalls, plus a long hold when requested
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (sink_idle && $urandom_range(99) < 27) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_verdict
        crcfc_pkg::verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_err("verdict with no frame pending");
            end else begin
                want = verdict_q.pop_front();
                check_field("status",       16'(m_tdata[2:0]),   16'(want.status));
                check_field("message_type", 16'(m_tdata[10:3]),  16'(want.message_type));
                check_field("is_height",    16'(m_tdata[11]),    16'(want.is_height));
                check_field("computed_crc", m_tdata[27:12],      want.computed_crc);
                check_field("received_crc", m_tdata[43:28],      want.received_crc);
                check_field("frame_length", 16'(m_tdata[51:44]), 16'(want.frame_length));
            end
        end
    end

    task automatic test_directed();
        build_frame(1, FR_GOOD, 1'b0);     send_frame();
        build_frame(3, FR_GOOD, 1'b1);     send_frame();
        build_frame(4, FR_GOOD, 1'b0);     send_frame();
        build_frame(6, FR_GOOD, 1'b1);     send_frame();
        build_frame(4, FR_BAD_START, 1'b0); send_frame();
        build_frame(4, FR_BAD_END, 1'b0);  send_frame();
        build_frame(4, FR_BAD_CRC, 1'b0);  send_frame();
        wait_idle();
    endtask

    task automatic test_long_frames();
        build_frame(256, FR_GOOD, 1'b1);   send_frame();
        build_frame(270, FR_BAD_CRC, 1'b0); send_frame();
        wait_idle();
    endtask

    task automatic test_full_rate();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (15) send_random_frame();
        wait_idle();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        src_idle = 1'b0;
        hold_req = 300;
        repeat (8) begin
            build_frame($urandom_range(6, 4), FR_GOOD, 1'b1);
            send_frame();
        end
        wait_idle();
        src_idle = 1'b1;
    endtask

    task automatic test_register_settings();
        logic [7:0] st_v [6];
        logic [7:0] en_v [6];
        logic [7:0] ht_v [6];
        int         mark;
        st_v = '{8'h00, 8'hFF, 8'hFF, 8'($urandom), 8'($urandom),
                 crcfc_pkg::START_MARKER_RST};
        en_v = '{8'hFF, 8'h00, 8'hFF, 8'($urandom), 8'($urandom),
                 crcfc_pkg::END_MARKER_RST};
        ht_v = '{8'h00, 8'hFF, 8'h80, 8'($urandom), 8'($urandom),
                 crcfc_pkg::HEIGHT_TYPE_RST};
        for (int p = 0; p < 6; p++) begin
            set_regs(st_v[p], en_v[p], ht_v[p]);
            mark = bytes_sent;
            while (bytes_sent - mark < 180) send_random_frame();
            wait_idle();
        end
    endtask

    initial begin
        clear_track();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_long_frames();
        test_full_rate();
        test_backpressure();
        test_register_settings();
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("crc16_frame_checker_top: match");
        end else begin
            $display("crc16_frame_checker_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
